// File: src/lsem_pkg.sv
// Shared constants, types and the exponent table for the shard lse merge.
// Depends on nothing; every other file of the block imports it.
package lsem_pkg;

  localparam int SHARDS    = 4;
  localparam int SHARD_W   = (SHARDS > 1) ? $clog2(SHARDS) : 1;
  localparam int LSE_W     = 16;
  localparam int VAL_W     = 16;
  localparam int EXP_BITS  = 12;
  localparam int ACC_W     = 31;
  localparam int COEF_W    = 30;
  localparam int W_W       = 17;
  localparam int PROD_W    = 33;
  localparam int SUM_W     = W_W + SHARD_W;
  localparam int NUM_W     = PROD_W + SHARD_W;
  localparam int DIV_W     = NUM_W + 1;
  localparam int Q_BITS    = 16;
  localparam int FRAC_BITS = 16;
  localparam int K_W       = 5;
  localparam int L_W       = K_W + FRAC_BITS;
  localparam int Y_W       = 31;
  localparam int LANE_LAT  = EXP_BITS + 2;

  localparam logic signed [LSE_W-1:0] LSE_NEG_INF = 16'sh8000;
  localparam logic [15:0]             LN2_Q16     = 16'd45426;

  typedef struct packed {
    logic                    vld;
    logic                    any;
    logic signed [LSE_W-1:0] m;
  } lsem_ctl_t;

  function automatic logic [COEF_W-1:0] exp_coef(input int j);
    logic [COEF_W-1:0] c;
    case (j)
      0:       c = 30'd1069555701;
      1:       c = 30'd1065385899;
      2:       c = 30'd1057095000;
      3:       c = 30'd1040706261;
      4:       c = 30'd1008687096;
      5:       c = 30'd947573834;
      6:       c = 30'd836230973;
      7:       c = 30'd651257337;
      8:       c = 30'd395007542;
      9:       c = 30'd145315154;
      10:      c = 30'd19666268;
      11:      c = 30'd360200;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: src/lsem_lane.sv
// One shard lane: weight exp(lse - max) by a product chain over the bits of
// the distance, then the weighted value. Depends on lsem_pkg.
module lsem_lane
  import lsem_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [LSE_W-1:0]  lse,
  input  logic signed [VAL_W-1:0]  value,
  input  logic signed [LSE_W-1:0]  m,
  output logic [W_W-1:0]           weight,
  output logic signed [PROD_W-1:0] prod
);

  logic [ACC_W-1:0]        acc_r  [0:EXP_BITS];
  logic [EXP_BITS-1:0]     d_r    [0:EXP_BITS];
  logic                    zero_r [0:EXP_BITS];
  logic signed [VAL_W-1:0] val_r  [0:EXP_BITS];
  logic signed [LSE_W:0]   gap;
  logic [ACC_W-1:0]        wsum;
  logic [W_W-1:0]          weight_nxt;
  logic [W_W-1:0]          weight_r;
  logic signed [PROD_W-1:0] prod_r;

  assign gap = {m[LSE_W-1], m} - {lse[LSE_W-1], lse};

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r[0]  <= ACC_W'(1) << 30;
      d_r[0]    <= gap[EXP_BITS-1:0];
      zero_r[0] <= (lse == LSE_NEG_INF) || (gap[LSE_W:EXP_BITS] != '0);
      val_r[0]  <= value;
    end
  end

  for (genvar j = 0; j < EXP_BITS; j++) begin : g_step
    logic [ACC_W+COEF_W-1:0] mul;
    logic [ACC_W+COEF_W-1:0] rnd;
    assign mul = (ACC_W+COEF_W)'(acc_r[j]) * (ACC_W+COEF_W)'(exp_coef(j));
    assign rnd = mul + ((ACC_W+COEF_W)'(1) << 29);
    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[j+1]  <= d_r[j][j] ? rnd[ACC_W+COEF_W-1:30] : acc_r[j];
        d_r[j+1]    <= d_r[j];
        zero_r[j+1] <= zero_r[j];
        val_r[j+1]  <= val_r[j];
      end
    end
  end

  assign wsum = acc_r[EXP_BITS] + (ACC_W'(1) << 13);
  assign weight_nxt = zero_r[EXP_BITS] ? '0 : wsum[ACC_W-1:14];

  always_ff @(posedge clk) begin
    if (en) begin
      weight_r <= weight_nxt;
      prod_r   <= PROD_W'(val_r[EXP_BITS] * $signed({1'b0, weight_nxt}));
    end
  end

  assign weight = weight_r;
  assign prod   = prod_r;

endmodule

// File: src/lsem_merge.sv
// Merging stage: sums lane weights and products, divides bit by bit and
// takes the log of the weight sum by squaring. Depends on lsem_pkg.
module lsem_merge
  import lsem_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  lsem_ctl_t                ctl,
  input  logic [W_W-1:0]           weight [SHARDS],
  input  logic signed [PROD_W-1:0] prod   [SHARDS],
  output logic                     out_valid,
  output logic signed [VAL_W-1:0]  merged_value,
  output logic signed [LSE_W-1:0]  joint_lse
);

  lsem_ctl_t               ctl_s_r;
  logic [SUM_W-1:0]        s_r;
  logic signed [NUM_W-1:0] n_r;
  logic [SUM_W-1:0]        s_sum;
  logic signed [NUM_W-1:0] n_sum;

  always_comb begin
    s_sum = '0;
    n_sum = '0;
    for (int i = 0; i < SHARDS; i++) begin
      s_sum = s_sum + SUM_W'(weight[i]);
      n_sum = n_sum + NUM_W'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s_r.vld <= 1'b0;
    end else if (en) begin
      ctl_s_r <= ctl;
      s_r     <= s_sum;
      n_r     <= n_sum;
    end
  end

  lsem_ctl_t        ctl_r [0:Q_BITS];
  logic [DIV_W-1:0] rem_r [0:Q_BITS];
  logic [SUM_W-1:0] dv_r  [0:Q_BITS];
  logic [Q_BITS-1:0] q_r  [0:Q_BITS];
  logic             neg_r [0:Q_BITS];
  logic             sat_r [0:Q_BITS];
  logic [Y_W-1:0]   y_r   [0:Q_BITS];
  logic [L_W-1:0]   l_r   [0:Q_BITS];

  logic [NUM_W-1:0] mag;
  logic [DIV_W-1:0] dvd;
  logic [K_W-1:0]   p;
  logic [31:0]      y_sh;

  always_comb begin
    mag = n_r[NUM_W-1] ? NUM_W'(-n_r) : NUM_W'(n_r);
    dvd = DIV_W'(mag) + DIV_W'(s_r >> 1);
    p   = K_W'(16);
    for (int b = 16; b < SUM_W; b++) begin
      if (s_r[b]) begin
        p = K_W'(b);
      end
    end
    y_sh = 32'(s_r) << (K_W'(30) - p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0].vld <= 1'b0;
    end else if (en) begin
      ctl_r[0] <= ctl_s_r;
      rem_r[0] <= dvd;
      dv_r[0]  <= s_r;
      q_r[0]   <= '0;
      neg_r[0] <= n_r[NUM_W-1];
      sat_r[0] <= dvd >= (DIV_W'(s_r) << Q_BITS);
      y_r[0]   <= y_sh[Y_W-1:0];
      l_r[0]   <= {p - K_W'(16), FRAC_BITS'(0)};
    end
  end

  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    logic [DIV_W-1:0]   shv;
    logic [2*Y_W-1:0]   sq;
    logic [Y_W:0]       yt;
    logic               ge;
    assign shv = DIV_W'(dv_r[k]) << (Q_BITS - 1 - k);
    assign ge  = rem_r[k] >= shv;
    assign sq  = (2*Y_W)'(y_r[k]) * (2*Y_W)'(y_r[k]);
    assign yt  = sq[2*Y_W-1:30];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1].vld <= 1'b0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
        rem_r[k+1] <= ge ? rem_r[k] - shv : rem_r[k];
        q_r[k+1]   <= q_r[k] | (Q_BITS'(ge) << (Q_BITS - 1 - k));
        dv_r[k+1]  <= dv_r[k];
        neg_r[k+1] <= neg_r[k];
        sat_r[k+1] <= sat_r[k];
        y_r[k+1]   <= yt[Y_W] ? yt[Y_W:1] : yt[Y_W-1:0];
        l_r[k+1]   <= l_r[k] | (L_W'(yt[Y_W]) << (FRAC_BITS - 1 - k));
      end
    end
  end

  logic [Q_BITS:0]         qs;
  logic [L_W+15:0]         ln_prod;
  logic [12:0]             ln_v;
  logic signed [LSE_W:0]   lse_sum;
  logic signed [VAL_W-1:0] value_nxt;
  logic signed [LSE_W-1:0] lse_nxt;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] merged_value_r;
  logic signed [LSE_W-1:0] joint_lse_r;

  always_comb begin
    qs = {1'b0, q_r[Q_BITS]};
    if (sat_r[Q_BITS] || qs > 17'd32768) begin
      qs = 17'd32768;
    end
    if (neg_r[Q_BITS]) begin
      value_nxt = VAL_W'(-qs);
    end else if (qs > 17'd32767) begin
      value_nxt = 16'sh7fff;
    end else begin
      value_nxt = VAL_W'(qs);
    end
    ln_prod = (L_W+16)'(l_r[Q_BITS]) * (L_W+16)'(LN2_Q16) + ((L_W+16)'(1) << 23);
    ln_v    = ln_prod[36:24];
    lse_sum = {ctl_r[Q_BITS].m[LSE_W-1], ctl_r[Q_BITS].m} + $signed({4'b0, ln_v});
    lse_nxt = (lse_sum > 17'sd32767) ? 16'sh7fff : lse_sum[LSE_W-1:0];
    if (!ctl_r[Q_BITS].any) begin
      value_nxt = '0;
      lse_nxt   = LSE_NEG_INF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r    <= ctl_r[Q_BITS].vld;
      merged_value_r <= value_nxt;
      joint_lse_r    <= lse_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign merged_value = merged_value_r;
  assign joint_lse    = joint_lse_r;

  a_sum_floor: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_s_r.vld && ctl_s_r.any |-> s_r >= SUM_W'(65536))
    else $error("weight sum below one with a valid shard");

  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[0].vld && ctl_r[0].any |-> y_r[0][Y_W-1])
    else $error("log operand not normalized");

  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[Q_BITS].vld && ctl_r[Q_BITS].any && !sat_r[Q_BITS]
      |-> rem_r[Q_BITS] < DIV_W'(dv_r[Q_BITS]))
    else $error("division remainder not below divisor");

endmodule

// File: src/attention_shard_lse_merge.sv
// Top level of the shard lse merge: input register, max search, the shard
// lanes and the merging stage. Depends on lsem_pkg, lsem_lane, lsem_merge.
// Throughput is one request per cycle while no result waits on out_ready,
// set by the fully pipelined lanes, divider and log chain.
// The whole pipeline holds while a result waits on out_ready.
// Reset (rst_n, synchronous) clears only the valid bits of the pipeline.
module attention_shard_lse_merge
  import lsem_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [LSE_W-1:0] in_shard0_lse,
  input  logic signed [LSE_W-1:0] in_shard1_lse,
  input  logic signed [LSE_W-1:0] in_shard2_lse,
  input  logic signed [LSE_W-1:0] in_shard3_lse,
  input  logic signed [VAL_W-1:0] in_shard0_value,
  input  logic signed [VAL_W-1:0] in_shard1_value,
  input  logic signed [VAL_W-1:0] in_shard2_value,
  input  logic signed [VAL_W-1:0] in_shard3_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_merged_value,
  output logic signed [LSE_W-1:0] out_joint_lse
);

  logic                    en;
  logic signed [LSE_W-1:0] lse_in  [SHARDS];
  logic signed [VAL_W-1:0] val_in  [SHARDS];
  logic                    a_vld_r;
  logic signed [LSE_W-1:0] lse_a_r [SHARDS];
  logic signed [VAL_W-1:0] val_a_r [SHARDS];
  logic signed [LSE_W-1:0] lse_b_r [SHARDS];
  logic signed [VAL_W-1:0] val_b_r [SHARDS];
  lsem_ctl_t               ctl_b_r;
  lsem_ctl_t               ctl_max;
  lsem_ctl_t               dly_r   [0:LANE_LAT-1];
  logic [W_W-1:0]          weight  [SHARDS];
  logic signed [PROD_W-1:0] prod   [SHARDS];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign lse_in[0] = in_shard0_lse;
  assign lse_in[1] = in_shard1_lse;
  assign lse_in[2] = in_shard2_lse;
  assign lse_in[3] = in_shard3_lse;
  assign val_in[0] = in_shard0_value;
  assign val_in[1] = in_shard1_value;
  assign val_in[2] = in_shard2_value;
  assign val_in[3] = in_shard3_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      lse_a_r <= lse_in;
      val_a_r <= val_in;
    end
  end

  always_comb begin
    ctl_max.vld = a_vld_r;
    ctl_max.any = 1'b0;
    ctl_max.m   = '0;
    for (int i = 0; i < SHARDS; i++) begin
      if (lse_a_r[i] != LSE_NEG_INF && (!ctl_max.any || lse_a_r[i] > ctl_max.m)) begin
        ctl_max.m   = lse_a_r[i];
        ctl_max.any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r.vld <= 1'b0;
      for (int i = 0; i < LANE_LAT; i++) begin
        dly_r[i].vld <= 1'b0;
      end
    end else if (en) begin
      ctl_b_r  <= ctl_max;
      lse_b_r  <= lse_a_r;
      val_b_r  <= val_a_r;
      dly_r[0] <= ctl_b_r;
      for (int i = 1; i < LANE_LAT; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  for (genvar g = 0; g < SHARDS; g++) begin : g_lane
    lsem_lane u_lane (
      .clk    (clk),
      .en     (en),
      .lse    (lse_b_r[g]),
      .value  (val_b_r[g]),
      .m      (ctl_b_r.m),
      .weight (weight[g]),
      .prod   (prod[g])
    );
  end

  lsem_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .ctl          (dly_r[LANE_LAT-1]),
    .weight       (weight),
    .prod         (prod),
    .out_valid    (out_valid),
    .merged_value (out_merged_value),
    .joint_lse    (out_joint_lse)
  );

endmodule
